// ----- rtl/ahh_pkg.sv -----
// shared types and constants for the auto headlight hysteresis controller
// no dependencies; used by the channel interface, the step logic and the top level
package ahh_pkg;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_AUTO = 2'd1,
		MODE_OFF  = 2'd2,
		MODE_ON   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		SUB_NONE   = 3'd0,
		SUB_ENTER  = 3'd1,
		SUB_OFF    = 3'd2,
		SUB_ON     = 3'd3,
		SUB_TO_OFF = 3'd4,
		SUB_TO_ON  = 3'd5
	} sub_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_READ      = 2'd1,
		ERR_SWITCH    = 2'd2,
		ERR_THRESHOLD = 2'd3
	} err_t;

	// driver switch codes
	localparam logic [7:0] SW_OFF  = 8'd0;
	localparam logic [7:0] SW_ON   = 8'd1;
	localparam logic [7:0] SW_AUTO = 8'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_OFF_THRESHOLD  = 2'd0;
	localparam logic [1:0] CFG_ON_THRESHOLD   = 2'd1;
	localparam logic [1:0] CFG_HOLD_OFF_TICKS = 2'd2;
	localparam logic [1:0] CFG_HOLD_ON_TICKS  = 2'd3;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	// register reset values
	localparam logic [7:0]  RST_OFF_THRESHOLD  = 8'd150;
	localparam logic [7:0]  RST_ON_THRESHOLD   = 8'd100;
	localparam logic [15:0] RST_HOLD_OFF_TICKS = 16'd300;
	localparam logic [15:0] RST_HOLD_ON_TICKS  = 16'd200;

	localparam logic [15:0] TIMER_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0]  switch_position;
		logic [15:0] light_level;
		logic        level_read_ok;
	} in_item_t;

	typedef struct packed {
		logic [1:0] error_code;
		logic       light_written;
		logic       light_on;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  off_threshold;
		logic [7:0]  on_threshold;
		logic [15:0] hold_off_ticks;
		logic [15:0] hold_on_ticks;
	} cfg_t;

	typedef struct packed {
		logic        started;
		mode_t       top_mode;
		sub_t        auto_substate;
		logic [15:0] hold_timer;
	} ctrl_state_t;

endpackage

// ----- rtl/ahh_stream_if.sv -----
// valid/ready channel carrying one item of a packed payload type
// depends on ahh_pkg for the default payload type
interface ahh_stream_if #(
	parameter type payload_t = ahh_pkg::in_item_t
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/ahh_step.sv -----
// one tick of the controller: error checks and the mode machine, combinational
// depends on ahh_pkg
module ahh_step (
	input  ahh_pkg::in_item_t    item,
	input  ahh_pkg::cfg_t        cfg,
	input  ahh_pkg::ctrl_state_t cur,
	output ahh_pkg::ctrl_state_t nxt,
	output ahh_pkg::out_item_t   result
);
	logic [15:0] off_th;
	logic [15:0] on_th;
	logic        above_off;
	logic        below_on;
	logic [15:0] timer_inc;
	ahh_pkg::err_t err;

	assign off_th    = {8'd0, cfg.off_threshold};
	assign on_th     = {8'd0, cfg.on_threshold};
	assign above_off = item.light_level > off_th;
	assign below_on  = item.light_level < on_th;
	assign timer_inc = (cur.hold_timer != ahh_pkg::TIMER_MAX) ? cur.hold_timer + 16'd1
		: cur.hold_timer;

	// first failing check wins: threshold, then switch, then read
	always_comb begin
		if (cfg.off_threshold < cfg.on_threshold) begin
			err = ahh_pkg::ERR_THRESHOLD;
		end else if (item.switch_position > ahh_pkg::SW_AUTO) begin
			err = ahh_pkg::ERR_SWITCH;
		end else if (!item.level_read_ok) begin
			err = ahh_pkg::ERR_READ;
		end else begin
			err = ahh_pkg::ERR_NONE;
		end
	end

	always_comb begin
		nxt                  = cur;
		result.error_code    = err;
		result.light_written = 1'b0;
		result.light_on      = 1'b0;
		if (err != ahh_pkg::ERR_NONE) begin
			result.light_written = 1'b1;
			result.light_on      = 1'b1;
		end else if (!cur.started) begin
			nxt.started  = 1'b1;
			nxt.top_mode = ahh_pkg::MODE_OFF;
		end else begin
			case (cur.top_mode)
				ahh_pkg::MODE_AUTO: begin
					if (item.switch_position == ahh_pkg::SW_ON) begin
						nxt.auto_substate = ahh_pkg::SUB_NONE;
						nxt.top_mode      = ahh_pkg::MODE_ON;
					end else if (item.switch_position == ahh_pkg::SW_OFF) begin
						nxt.auto_substate = ahh_pkg::SUB_NONE;
						nxt.top_mode      = ahh_pkg::MODE_OFF;
					end else begin
						case (cur.auto_substate)
							ahh_pkg::SUB_ENTER: begin
								nxt.auto_substate = above_off ? ahh_pkg::SUB_OFF
									: ahh_pkg::SUB_ON;
							end
							ahh_pkg::SUB_OFF: begin
								if (below_on) begin
									nxt.auto_substate = ahh_pkg::SUB_TO_ON;
								end else begin
									result.light_written = 1'b1;
									nxt.hold_timer       = '0;
								end
							end
							ahh_pkg::SUB_ON: begin
								if (above_off) begin
									nxt.auto_substate = ahh_pkg::SUB_TO_OFF;
								end else begin
									result.light_written = 1'b1;
									result.light_on      = 1'b1;
									nxt.hold_timer       = '0;
								end
							end
							ahh_pkg::SUB_TO_OFF: begin
								if (!above_off) begin
									nxt.auto_substate = ahh_pkg::SUB_ON;
								end else if (cur.hold_timer >= cfg.hold_off_ticks) begin
									nxt.auto_substate = ahh_pkg::SUB_OFF;
								end else begin
									nxt.hold_timer = timer_inc;
								end
							end
							default: begin
								// to-on; the no-substate code and the unused codes behave the same
								if (!below_on) begin
									nxt.auto_substate = ahh_pkg::SUB_OFF;
								end else if (cur.hold_timer >= cfg.hold_on_ticks) begin
									nxt.auto_substate = ahh_pkg::SUB_ON;
								end else begin
									nxt.hold_timer    = timer_inc;
									nxt.auto_substate = ahh_pkg::SUB_TO_ON;
								end
							end
						endcase
					end
				end
				ahh_pkg::MODE_OFF: begin
					case (item.switch_position)
						ahh_pkg::SW_AUTO: begin
							nxt.top_mode      = ahh_pkg::MODE_AUTO;
							nxt.auto_substate = ahh_pkg::SUB_ENTER;
						end
						ahh_pkg::SW_ON: begin
							nxt.top_mode = ahh_pkg::MODE_ON;
						end
						default: begin
							result.light_written = 1'b1;
						end
					endcase
				end
				default: begin
					// on mode; a started block with no mode acts the same
					case (item.switch_position)
						ahh_pkg::SW_OFF: begin
							nxt.top_mode = ahh_pkg::MODE_OFF;
						end
						ahh_pkg::SW_AUTO: begin
							nxt.top_mode      = ahh_pkg::MODE_AUTO;
							nxt.auto_substate = ahh_pkg::SUB_ENTER;
						end
						default: begin
							result.light_written = 1'b1;
							result.light_on      = 1'b1;
							nxt.top_mode         = ahh_pkg::MODE_ON;
						end
					endcase
				end
			endcase
		end
	end
endmodule

// ----- rtl/auto_headlight_hysteresis_ctrl_unit.sv -----
// top level of the auto headlight hysteresis controller
// depends on ahh_pkg, ahh_stream_if and ahh_step
//
// throughput: one item per cycle while the output is not back-pressured; the only loop is the controller state register
// reset: arst_n clears control state and loads the register defaults
//        (off 150, on 100, hold off 300, hold on 200); no clearing pass
module auto_headlight_hysteresis_ctrl_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	ahh_stream_if.sink                            in_ch,
	ahh_stream_if.source                          out_ch,
	input  logic                                  cfg_we,
	input  logic [ahh_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [ahh_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	// configuration registers
	ahh_pkg::cfg_t cfg_q;

	// input stage
	logic              valid_s1;
	ahh_pkg::in_item_t item_s1;

	// result stage
	logic               valid_s2;
	ahh_pkg::out_item_t result_s2;

	// controller state
	ahh_pkg::ctrl_state_t state_q;
	ahh_pkg::ctrl_state_t state_next;
	ahh_pkg::out_item_t   result_next;

	logic advance;
	logic take_in;

	// the input stage moves on whenever the result stage is free or being drained
	assign advance = valid_s1 && (!valid_s2 || out_ch.ready);
	assign take_in = in_ch.valid && in_ch.ready;

	assign in_ch.ready    = !valid_s1 || advance;
	assign out_ch.valid   = valid_s2;
	assign out_ch.payload = result_s2;

	// user must write registers only while idle; unenforced, no interlock with items in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off_threshold  <= ahh_pkg::RST_OFF_THRESHOLD;
			cfg_q.on_threshold   <= ahh_pkg::RST_ON_THRESHOLD;
			cfg_q.hold_off_ticks <= ahh_pkg::RST_HOLD_OFF_TICKS;
			cfg_q.hold_on_ticks  <= ahh_pkg::RST_HOLD_ON_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				ahh_pkg::CFG_OFF_THRESHOLD:  cfg_q.off_threshold  <= cfg_wdata[7:0];
				ahh_pkg::CFG_ON_THRESHOLD:   cfg_q.on_threshold   <= cfg_wdata[7:0];
				ahh_pkg::CFG_HOLD_OFF_TICKS: cfg_q.hold_off_ticks <= cfg_wdata;
				ahh_pkg::CFG_HOLD_ON_TICKS:  cfg_q.hold_on_ticks  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// tick logic sits between the input register and the result register
	ahh_step u_step (
		.item   (item_s1),
		.cfg    (cfg_q),
		.cur    (state_q),
		.nxt    (state_next),
		.result (result_next)
	);

	// state commits in item order, at the edge the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.started       <= 1'b0;
			state_q.top_mode      <= ahh_pkg::MODE_NONE;
			state_q.auto_substate <= ahh_pkg::SUB_NONE;
			state_q.hold_timer    <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= in_ch.payload;
		end
	end

	// result stage control: filled by the input stage, emptied by the sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench for auto_headlight_hysteresis_ctrl_unit
// depends on ahh_pkg, ahh_stream_if and the unit's rtl; items are predicted in-line
module tb_top;
	import ahh_pkg::*;

	localparam int          CLK_HALF    = 5;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          IDLE_PCT    = 16;

	logic clk = 1'b0;
	logic arst_n;

	ahh_stream_if #(.payload_t(in_item_t))  in_ch ();
	ahh_stream_if #(.payload_t(out_item_t)) out_ch ();

	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// local copy of the registers and of the controller state
	cfg_t        lamp_cfg;
	ctrl_state_t lamp_state;
	// headlight commands still owed by the unit, oldest first
	out_item_t   headlight_cmd_q[$];

	int          fail_count = 0;
	bit          idle_on = 1'b1;
	int unsigned cycle_count = 0;

	auto_headlight_hysteresis_ctrl_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// one line per mismatch, printing capped so a broken unit cannot flood the log
	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < 100)
			$display("mismatch: %s got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
		fail_count++;
	endtask

	// one tick of the controller: error checks, then the mode machine
	function automatic out_item_t headlight_step(in_item_t it);
		out_item_t r;
		err_t      err;
		r   = '0;
		err = ERR_NONE;
		// later checks override earlier ones
		if (!it.level_read_ok)
			err = ERR_READ;
		if (it.switch_position > SW_AUTO)
			err = ERR_SWITCH;
		if (lamp_cfg.off_threshold < lamp_cfg.on_threshold)
			err = ERR_THRESHOLD;
		r.error_code = err;

		if (err != ERR_NONE) begin
			// fail safe: light forced on, state frozen
			r.light_written = 1'b1;
			r.light_on      = 1'b1;
		end else if (!lamp_state.started) begin
			// first clean tick only wakes the machine up in off mode
			lamp_state.started  = 1'b1;
			lamp_state.top_mode = MODE_OFF;
		end else if (lamp_state.top_mode == MODE_AUTO) begin
			if (it.switch_position == SW_ON) begin
				lamp_state.auto_substate = SUB_NONE;
				lamp_state.top_mode      = MODE_ON;
			end else if (it.switch_position == SW_OFF) begin
				lamp_state.auto_substate = SUB_NONE;
				lamp_state.top_mode      = MODE_OFF;
			end else begin
				case (lamp_state.auto_substate)
					SUB_ENTER: begin
						lamp_state.auto_substate =
							(it.light_level > lamp_cfg.off_threshold) ? SUB_OFF : SUB_ON;
					end
					SUB_OFF: begin
						if (it.light_level < lamp_cfg.on_threshold) begin
							lamp_state.auto_substate = SUB_TO_ON;
						end else begin
							r.light_written       = 1'b1;
							r.light_on            = 1'b0;
							lamp_state.hold_timer = '0;
						end
					end
					SUB_ON: begin
						if (it.light_level > lamp_cfg.off_threshold) begin
							lamp_state.auto_substate = SUB_TO_OFF;
						end else begin
							r.light_written       = 1'b1;
							r.light_on            = 1'b1;
							lamp_state.hold_timer = '0;
						end
					end
					SUB_TO_OFF: begin
						if (it.light_level <= lamp_cfg.off_threshold)
							lamp_state.auto_substate = SUB_ON;
						else if (lamp_state.hold_timer >= lamp_cfg.hold_off_ticks)
							lamp_state.auto_substate = SUB_OFF;
						else if (lamp_state.hold_timer != TIMER_MAX)
							lamp_state.hold_timer = lamp_state.hold_timer + 16'd1;
					end
					default: begin
						// to-on, and any odd code behaves the same way
						if (it.light_level >= lamp_cfg.on_threshold) begin
							lamp_state.auto_substate = SUB_OFF;
						end else if (lamp_state.hold_timer >= lamp_cfg.hold_on_ticks) begin
							lamp_state.auto_substate = SUB_ON;
						end else begin
							if (lamp_state.hold_timer != TIMER_MAX)
								lamp_state.hold_timer = lamp_state.hold_timer + 16'd1;
							lamp_state.auto_substate = SUB_TO_ON;
						end
					end
				endcase
			end
		end else if (lamp_state.top_mode == MODE_OFF) begin
			if (it.switch_position == SW_AUTO) begin
				lamp_state.top_mode      = MODE_AUTO;
				lamp_state.auto_substate = SUB_ENTER;
			end else if (it.switch_position == SW_ON) begin
				lamp_state.top_mode = MODE_ON;
			end else begin
				r.light_written = 1'b1;
				r.light_on      = 1'b0;
			end
		end else begin
			// on mode (a started machine with no mode acts the same)
			if (it.switch_position == SW_OFF) begin
				lamp_state.top_mode = MODE_OFF;
			end else if (it.switch_position == SW_AUTO) begin
				lamp_state.top_mode      = MODE_AUTO;
				lamp_state.auto_substate = SUB_ENTER;
			end else begin
				r.light_written     = 1'b1;
				r.light_on          = 1'b1;
				lamp_state.top_mode = MODE_ON;
			end
		end
		return r;
	endfunction

	// offer one item, wait for the handshake, then record what it must produce
	task automatic send_reading(input logic [7:0] sw, input logic [15:0] lvl, input logic ok);
		in_item_t it;
		it.switch_position = sw;
		it.light_level     = lvl;
		it.level_read_ok   = ok;
		if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_ch.payload <= it;
		in_ch.valid   <= 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		headlight_cmd_q.push_back(headlight_step(it));
	endtask

	// stop offering and let every owed command come out, plus a little slack
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (headlight_cmd_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// single register write; the gap cycle keeps cfg_we from toggling twice in a step
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_OFF_THRESHOLD:  lamp_cfg.off_threshold  = val[7:0];
			CFG_ON_THRESHOLD:   lamp_cfg.on_threshold   = val[7:0];
			CFG_HOLD_OFF_TICKS: lamp_cfg.hold_off_ticks = val;
			CFG_HOLD_ON_TICKS:  lamp_cfg.hold_on_ticks  = val;
			default: ;
		endcase
	endtask

	// all four registers; only ever called with the unit drained
	task automatic apply_config(input int off_th, input int on_th, input int hold_off,
			input int hold_on);
		write_reg(CFG_OFF_THRESHOLD, CFG_DATA_W'(off_th));
		write_reg(CFG_ON_THRESHOLD, CFG_DATA_W'(on_th));
		write_reg(CFG_HOLD_OFF_TICKS, CFG_DATA_W'(hold_off));
		write_reg(CFG_HOLD_ON_TICKS, CFG_DATA_W'(hold_on));
	endtask

	// hand-picked walk through errors, every mode and every auto substate at reset values
	task automatic test_directed();
		send_reading(SW_OFF, 16'd0, 1'b0);      // read failure before start, nothing moves
		send_reading(8'd3, 16'hFFFF, 1'b1);     // smallest bad switch
		send_reading(8'hFF, 16'd0, 1'b0);       // both errors, switch code wins
		send_reading(SW_OFF, 16'd0, 1'b1);      // first clean tick: start in off
		send_reading(SW_OFF, 16'd0, 1'b1);      // off mode drives light off
		send_reading(SW_ON, 16'd0, 1'b1);       // off -> on, no write
		send_reading(SW_ON, 16'd0, 1'b1);       // on mode drives light on
		send_reading(SW_OFF, 16'd0, 1'b1);      // on -> off
		send_reading(SW_ON, 16'd0, 1'b1);
		send_reading(SW_AUTO, 16'd200, 1'b1);   // on -> auto enter
		send_reading(SW_AUTO, 16'd200, 1'b1);   // bright: enter -> steady off
		send_reading(SW_AUTO, 16'd100, 1'b1);   // level equal to on threshold stays off
		send_reading(SW_AUTO, 16'd99, 1'b1);    // dark: off -> to-on
		send_reading(SW_AUTO, 16'd99, 1'b1);    // timer counts
		send_reading(SW_AUTO, 16'd100, 1'b1);   // light back: to-on -> off
		send_reading(SW_AUTO, 16'd0, 1'b1);
		send_reading(SW_ON, 16'd0, 1'b1);       // leave auto, timer kept
		send_reading(SW_AUTO, 16'd150, 1'b1);
		send_reading(SW_AUTO, 16'd150, 1'b1);   // level equal to off threshold: enter -> on
		send_reading(SW_AUTO, 16'd150, 1'b1);   // steady on writes and clears timer
		send_reading(SW_AUTO, 16'd151, 1'b1);   // on -> to-off
		send_reading(SW_AUTO, 16'd151, 1'b1);
		send_reading(SW_AUTO, 16'd150, 1'b1);   // to-off falls back to on
		send_reading(SW_AUTO, 16'hFFFF, 1'b0);  // read failure inside auto
		send_reading(SW_OFF, 16'd0, 1'b1);      // auto -> off
		drain_results();
	endtask

	// off threshold just under on threshold flags every tick; equal is legal
	task automatic test_threshold_error();
		apply_config(99, 100, RST_HOLD_OFF_TICKS, RST_HOLD_ON_TICKS);
		send_reading(SW_AUTO, 16'd50, 1'b1);
		send_reading(8'd7, 16'd50, 1'b0);
		send_reading(SW_OFF, 16'd300, 1'b1);
		drain_results();
		apply_config(100, 100, RST_HOLD_OFF_TICKS, RST_HOLD_ON_TICKS);
		send_reading(SW_AUTO, 16'd100, 1'b1);
		send_reading(SW_AUTO, 16'd100, 1'b1);
		send_reading(SW_AUTO, 16'd99, 1'b1);
		send_reading(SW_AUTO, 16'd101, 1'b1);
		send_reading(SW_OFF, 16'd0, 1'b1);
		drain_results();
	endtask

	// zero hold times switch at once on the stale count, short ones time out
	task automatic test_hold_times();
		int k;
		apply_config(150, 100, 0, 0);
		send_reading(SW_AUTO, 16'd0, 1'b1);
		send_reading(SW_AUTO, 16'd0, 1'b1);
		send_reading(SW_AUTO, 16'd200, 1'b1);
		send_reading(SW_AUTO, 16'd200, 1'b1);
		send_reading(SW_AUTO, 16'd50, 1'b1);
		send_reading(SW_AUTO, 16'd50, 1'b1);
		send_reading(SW_AUTO, 16'd50, 1'b1);
		drain_results();
		apply_config(150, 100, 3, 2);
		for (k = 0; k < 7; k++)
			send_reading(SW_AUTO, 16'd200, 1'b1);
		for (k = 0; k < 6; k++)
			send_reading(SW_AUTO, 16'd50, 1'b1);
		drain_results();
	endtask

	// long hold on time: darkness held past the hold count, no idling
	task automatic test_long_hold();
		int k;
		apply_config(150, 100, RST_HOLD_OFF_TICKS, 150);
		idle_on = 1'b0;
		send_reading(SW_OFF, 16'd0, 1'b1);
		send_reading(SW_AUTO, 16'd0, 1'b1);
		send_reading(SW_AUTO, 16'd255, 1'b1);
		for (k = 0; k < 160; k++)
			send_reading(SW_AUTO, 16'd0, 1'b1);
		drain_results();
		idle_on = 1'b1;
	endtask

	// phases of corner and random settings; bursts of dark, bright, near-threshold or random light mostly in auto
	task automatic test_random();
		int phase, k, r;
		int off_v, on_v, hoff_v, hon_v;
		int burst_left, burst_kind, lvl;
		logic [7:0] sw;
		for (phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin off_v = 255; on_v = 0;   hoff_v = 0;     hon_v = 0;     end
				1: begin off_v = 0;   on_v = 0;   hoff_v = 1;     hon_v = 1;     end
				2: begin off_v = 255; on_v = 255; hoff_v = 65535; hon_v = 65535; end
				3: begin
					off_v  = $urandom_range(0, 255);
					on_v   = $urandom_range(0, 255);
					hoff_v = $urandom_range(0, 65535);
					hon_v  = $urandom_range(0, 65535);
				end
				default: begin
					on_v   = $urandom_range(0, 255);
					off_v  = $urandom_range(on_v, 255);
					hoff_v = $urandom_range(0, 12);
					hon_v  = $urandom_range(0, 12);
				end
			endcase
			apply_config(off_v, on_v, hoff_v, hon_v);
			burst_left = 0;
			burst_kind = 0;
			for (k = 0; k < 80; k++) begin
				if (burst_left == 0) begin
					burst_kind = $urandom_range(0, 4);
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;
				case (burst_kind)
					0: lvl = (on_v == 0) ? 0 : $urandom_range(0, on_v - 1);
					1: lvl = off_v + int'($urandom_range(1, 40));
					2: lvl = ($urandom_range(0, 1) ? off_v : on_v) + int'($urandom_range(0, 4)) - 2;
					3: lvl = $urandom_range(0, 300);
					default: lvl = $urandom_range(0, 65535);
				endcase
				if (lvl < 0)
					lvl = 0;
				r = $urandom_range(0, 99);
				if (r < 72)
					sw = SW_AUTO;
				else if (r < 82)
					sw = SW_OFF;
				else if (r < 92)
					sw = SW_ON;
				else
					sw = 8'($urandom_range(0, 255));
				send_reading(sw, 16'(lvl), ($urandom_range(0, 99) >= 6));
			end
			drain_results();
		end
	endtask

	// result side: random back-pressure and the field by field check
	always @(posedge clk) begin : result_check
		out_item_t got;
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			if (headlight_cmd_q.size() == 0) begin
				report_mismatch("unexpected item, error_code", got.error_code, -1);
			end else begin
				want = headlight_cmd_q.pop_front();
				if (got.error_code !== want.error_code)
					report_mismatch("error_code", got.error_code, want.error_code);
				if (got.light_written !== want.light_written)
					report_mismatch("light_written", got.light_written, want.light_written);
				if (got.light_on !== want.light_on)
					report_mismatch("light_on", got.light_on, want.light_on);
			end
		end
		out_ch.ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.payload  = '0;
		out_ch.ready   = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		lamp_cfg       = '{RST_OFF_THRESHOLD, RST_ON_THRESHOLD,
			RST_HOLD_OFF_TICKS, RST_HOLD_ON_TICKS};
		lamp_state     = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_threshold_error();
		test_hold_times();
		test_long_hold();
		test_random();
		drain_results();

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
